### src/ola_pkg.sv
// ----------------------------------------------------------------------------
// Overlap-add package
// Shared widths, register indexes, operation codes and the structs that pass
// between the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package ola_pkg;

  localparam int MAX_FRAME_DEF   = 1024;
  localparam int MAX_OVERLAP_DEF = 16;

  localparam int SAMPLE_BITS = 24;
  localparam int OUT_BITS    = 28;
  localparam int OUT_TDATA_W = 32;

  localparam int FRAME_W = 11;
  localparam int OVL_W   = 5;
  localparam int HOP_W   = 10;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 10;

  // Push position before reduction: slot * hop + push count.
  localparam int DIVIDEND_W = SLOT_W + HOP_W + 1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_SIZE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OVERLAP    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HOP        = 2'd2;

  localparam logic [FRAME_W-1:0] FRAME_SIZE_RST = 11'd1024;
  localparam logic [OVL_W-1:0]   OVERLAP_RST    = 5'd4;
  localparam logic [HOP_W-1:0]   HOP_RST        = 10'd256;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic ready;
    logic pop;
  } back_status_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_size;
    logic [OVL_W-1:0]   overlap;
    logic [HOP_W-1:0]   hop;
  } cfg_t;

endpackage

### src/ola_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ola_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ola_front.sv
// ----------------------------------------------------------------------------
// Overlap-add front end
// Accepts input requests, decodes the operation and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module ola_front import ola_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_BITS-1:0] in_tdata,   // [23:0] sample
  input  logic                   in_tuser,   // [0] operation
  output queue_head_t            head,
  input  back_status_t           status
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW      = $clog2(QUEUE_DEPTH + 1);

  item_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  item_t              in_item;
  logic               accept;

  // Classify the incoming request.
  assign in_item.op     = op_t'(in_tuser);
  assign in_item.sample = signed'(in_tdata);

  assign in_tready = status.ready && (count_r != CNT_QW'(QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;

  assign head.valid = (count_r != '0);
  assign head.item  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (accept && !status.pop) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (!accept && status.pop) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (status.pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

### src/ola_back.sv
// ----------------------------------------------------------------------------
// Overlap-add back end
// Clears the frame store after reset, then executes queued pushes and ticks
// against the store and drives the output register.
// ----------------------------------------------------------------------------
module ola_back import ola_pkg::*; #(
  parameter int MAX_FRAME   = MAX_FRAME_DEF,
  parameter int MAX_OVERLAP = MAX_OVERLAP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  queue_head_t         head,
  output back_status_t        status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_sample
);

  localparam int DEPTH  = MAX_FRAME * MAX_OVERLAP;
  localparam int AW     = $clog2(DEPTH);
  localparam int STEP_W = $clog2(DIVIDEND_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WRITE,
    S_TICK,
    S_OUT
  } state_t;

  state_t                   state_r;
  logic [AW-1:0]            clr_addr_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [CNT_W-1:0]         pcount_r;
  logic [CNT_W-1:0]         rpos_r;
  logic [SAMPLE_BITS-1:0]   sample_r;
  logic [DIVIDEND_W-1:0]    dividend_r;
  logic [FRAME_W-1:0]       rem_r;
  logic [STEP_W-1:0]        step_r;
  logic [OVL_W-1:0]         k_r;
  logic [FRAME_W-1:0]       rp_r;
  logic                     rd_pend_r;
  logic [OUT_BITS-1:0]      acc_r;
  logic                     out_valid_r;
  logic [OUT_BITS-1:0]      out_sample_r;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0]   ram_wdata, ram_rdata;

  logic [FRAME_W:0]         div_trial;
  logic [FRAME_W-1:0]       rem_nxt;
  logic                     issue;
  logic [FRAME_W-1:0]       pc_inc, rp_inc;
  logic [OVL_W-1:0]         slot_inc;

  ola_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status.ready = (state_r != S_CLEAR);
  assign status.pop   = (state_r == S_IDLE) && head.valid;

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // One restoring step of the remainder by the frame size.
  assign div_trial = {rem_r, dividend_r[DIVIDEND_W-1]};
  assign rem_nxt   = (div_trial >= {1'b0, cfg.frame_size})
                   ? FRAME_W'(div_trial - {1'b0, cfg.frame_size})
                   : div_trial[FRAME_W-1:0];

  assign issue    = (k_r < cfg.overlap);
  assign pc_inc   = {1'b0, pcount_r} + FRAME_W'(1);
  assign rp_inc   = rp_r + FRAME_W'(1);
  assign slot_inc = {1'b0, slot_r} + OVL_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    ram_raddr = AW'(32'(k_r) * 32'(MAX_FRAME) + 32'(rp_r));
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_WRITE: begin
        ram_we    = (32'(slot_r) < 32'(MAX_OVERLAP));
        ram_waddr = AW'(32'(slot_r) * 32'(MAX_FRAME) + 32'(rem_r));
        ram_wdata = sample_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      slot_r      <= '0;
      pcount_r    <= '0;
      rpos_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            if (head.item.op == OP_PUSH) begin
              sample_r <= head.item.sample;
              state_r  <= S_MUL;
            end else begin
              rp_r      <= ({1'b0, rpos_r} >= cfg.frame_size) ? '0 : {1'b0, rpos_r};
              k_r       <= '0;
              rd_pend_r <= 1'b0;
              acc_r     <= '0;
              state_r   <= S_TICK;
            end
          end
        end
        S_MUL: begin
          dividend_r <= DIVIDEND_W'(slot_r) * DIVIDEND_W'(cfg.hop)
                      + DIVIDEND_W'(pcount_r);
          rem_r      <= '0;
          step_r     <= '0;
          state_r    <= S_DIV;
        end
        S_DIV: begin
          rem_r      <= rem_nxt;
          dividend_r <= dividend_r << 1;
          step_r     <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (pc_inc >= cfg.frame_size) begin
            pcount_r <= '0;
            slot_r   <= (slot_inc >= cfg.overlap) ? '0 : slot_inc[SLOT_W-1:0];
          end else begin
            pcount_r <= pc_inc[CNT_W-1:0];
          end
          state_r <= S_IDLE;
        end
        S_TICK: begin
          if (issue) begin
            k_r <= k_r + OVL_W'(1);
          end
          rd_pend_r <= issue;
          if (rd_pend_r) begin
            acc_r <= acc_r + OUT_BITS'(signed'(ram_rdata));
          end
          if (!issue && !rd_pend_r) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= acc_r;
            rpos_r       <= (rp_inc >= cfg.frame_size) ? '0 : rp_inc[CNT_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/overlap_add_resynthesis.sv
// ----------------------------------------------------------------------------
// Overlap-add resynthesis buffer
// Sums overlapping frames written one sample at a time into per-slot storage
// and emits one summed output sample per tick request.
// ----------------------------------------------------------------------------
// A push request (tuser low) writes one frame sample into the current slot,
// rotated so that the frame begins at slot times hop modulo the frame size;
// after a full frame the slot advances modulo the overlap count. A tick
// request (tuser high) returns the exact sum of all active slots at the read
// position, which then advances modulo the frame size. In the back end a
// push takes the request, forms the slot-times-hop product, reduces it by
// the frame size with a bit-serial restoring remainder and writes the store.
// A tick is paced by the single read port of the frame store, which returns
// one slot per cycle: it takes the request, issues one read per slot, adds
// the last word, sees the sum complete and loads the output register. A
// two-entry queue sits in front, and a finished sum waits in the output
// register while the next request is taken. After reset the store of
// MAX_FRAME * MAX_OVERLAP words (16384 by default) is cleared one word per
// cycle; no request is taken during that time, but configuration writes are.
// Configuration must be written only while the block is idle; the block
// itself does not enforce it. Frame size and overlap count of zero act as one
// and values above the maximums saturate.
// ----------------------------------------------------------------------------
module overlap_add_resynthesis import ola_pkg::*; #(
  parameter int MAX_FRAME   = MAX_FRAME_DEF,
  parameter int MAX_OVERLAP = MAX_OVERLAP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_BITS-1:0] in_tdata,   // [23:0] sample
  input  logic                   in_tuser,   // [0] operation
  // Output stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [27:0] out_sample, [31:28] zero
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [FRAME_W-1:0]  frame_size_r;
  logic [OVL_W-1:0]    overlap_r;
  logic [HOP_W-1:0]    hop_r;
  cfg_t                cfg_eff;
  queue_head_t         head;
  back_status_t        status;
  logic [OUT_BITS-1:0] out_sample;

  // Registers are plain write-only; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RST;
      overlap_r    <= OVERLAP_RST;
      hop_r        <= HOP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_SIZE: frame_size_r <= cfg_wdata;
        REG_OVERLAP:    overlap_r    <= cfg_wdata[OVL_W-1:0];
        REG_HOP:        hop_r        <= cfg_wdata[HOP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the frame size and overlap count into the range the store holds.
  always_comb begin
    if (frame_size_r == '0) begin
      cfg_eff.frame_size = FRAME_W'(1);
    end else if (32'(frame_size_r) > 32'(MAX_FRAME)) begin
      cfg_eff.frame_size = FRAME_W'(MAX_FRAME);
    end else begin
      cfg_eff.frame_size = frame_size_r;
    end
    if (overlap_r == '0) begin
      cfg_eff.overlap = OVL_W'(1);
    end else if (32'(overlap_r) > 32'(MAX_OVERLAP)) begin
      cfg_eff.overlap = OVL_W'(MAX_OVERLAP);
    end else begin
      cfg_eff.overlap = overlap_r;
    end
    cfg_eff.hop = hop_r;
  end

  ola_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .status    (status)
  );

  ola_back #(
    .MAX_FRAME   (MAX_FRAME),
    .MAX_OVERLAP (MAX_OVERLAP)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_eff),
    .head       (head),
    .status     (status),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample)
  );

  // The sum sits in the low bits; the upper bits pad to a whole byte.
  assign out_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_sample};

endmodule
